// ----- rtl/core/thcc_pkg.sv -----
package thcc_pkg;

	localparam int ID_W       = 6;
	localparam int HITS_W     = 8;
	localparam int WEIGHT_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 3'd0,
		REG_INC_WEIGHT = 3'd1,
		REG_DEC_WEIGHT = 3'd2,
		REG_MAX_HITS   = 3'd3,
		REG_THRESHOLD  = 3'd4
	} cfg_reg_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DET_RD,
		ST_DET_WR,
		ST_SWP_RD,
		ST_SWP_EV,
		ST_FIN
	} state_t;

	typedef enum logic {
		ALU_ADD_CLAMP,
		ALU_SUB_FLOOR
	} alu_op_t;

endpackage

// ----- rtl/core/thcc_alu.sv -----
module thcc_alu import thcc_pkg::*; #(
	parameter int COUNT_BITS = 8
) (
	input  alu_op_t               op,
	input  logic [COUNT_BITS-1:0] cnt,
	input  logic [WEIGHT_W-1:0]   weight,
	input  logic [WEIGHT_W-1:0]   max_hits,
	input  logic [WEIGHT_W-1:0]   threshold,
	output logic [COUNT_BITS-1:0] result,
	output logic                  ge
);

	localparam int WW = ((COUNT_BITS > WEIGHT_W) ? COUNT_BITS : WEIGHT_W) + 1;
	localparam logic [WW-1:0] COUNT_MAX = WW'((1 << COUNT_BITS) - 1);

	logic [WW-1:0] a_ext;
	logic [WW-1:0] b_ext;
	logic [WW-1:0] max_ext;
	logic [WW-1:0] cap;
	logic [WW-1:0] raw;
	logic [WW-1:0] res;

	always_comb begin
		a_ext   = WW'(cnt);
		b_ext   = WW'(weight);
		max_ext = WW'(max_hits);
		cap     = (max_ext < COUNT_MAX) ? max_ext : COUNT_MAX;
		raw     = (op == ALU_ADD_CLAMP) ? a_ext + b_ext : a_ext - b_ext;
		case (op)
			ALU_ADD_CLAMP: res = (raw > cap) ? cap : raw;
			ALU_SUB_FLOOR: res = (a_ext > b_ext) ? raw : '0;
			default:       res = '0;
		endcase
		result = res[COUNT_BITS-1:0];
		ge     = a_ext >= WW'(threshold);
	end

endmodule

// ----- rtl/core/tag_hit_count_tracker_core.sv -----
// Keeps a saturating confidence count per marker id. For a detection beat (tuser 0)
// the count is read from a single-port memory, updated by the shared add/subtract
// unit and written back. An end-of-frame beat (tuser 1) sweeps the ids in ascending
// order, each id as a memory read, then evaluate and write back, followed by a final
// step; the output can be held off by m_tready. With enable low it only clears the
// frame flags, and a detection that is ignored (enable low or id out of range) is
// accepted and dropped. s_tready is high only between items. Each swept frame gives
// the qualifying ids, last one flagged with tlast, or a single marker beat with tuser 0
// when none qualifies. Counts read as zero after reset through per-entry valid bits,
// so no clearing pass is needed.
module tag_hit_count_tracker_core import thcc_pkg::*; #(
	parameter int ID_COUNT   = 64,
	parameter int COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // tag_id[5:0], point_valid[6], zero[7]
	input  logic                  s_tuser,  // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // out_id[5:0], out_hits[13:6], zero[15:14]
	output logic                  m_tuser,  // publish
	output logic                  m_tlast
);

	localparam int AW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam int WW = ((COUNT_BITS > HITS_W) ? COUNT_BITS : HITS_W) + 1;
	localparam logic [AW-1:0] IDX_LAST = AW'(ID_COUNT - 1);
	localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(ID_COUNT);

	// configuration
	logic                enable_q;
	logic [WEIGHT_W-1:0] inc_q;
	logic [WEIGHT_W-1:0] dec_q;
	logic [WEIGHT_W-1:0] max_q;
	logic [WEIGHT_W-1:0] thr_q;

	state_t state_q, state_d;

	// count memory and per-entry flags
	logic [COUNT_BITS-1:0] mem [ID_COUNT];
	logic [ID_COUNT-1:0]   ok_q;
	logic [ID_COUNT-1:0]   seen_q;
	logic [ID_COUNT-1:0]   pv_flags_q;
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  rd_ok_q;

	logic [AW-1:0] id_q;
	logic          pv_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] addr;

	logic                  pend_valid_q;
	logic [AW-1:0]         pend_id_q;
	logic [COUNT_BITS-1:0] pend_hits_q;
	logic [WW-1:0]         pend_ext;

	logic              out_valid_q;
	logic [ID_W-1:0]   out_id_q;
	logic [HITS_W-1:0] out_hits_q;
	logic              out_pub_q;
	logic              out_last_q;

	logic [ID_W-1:0]       in_id;
	logic                  in_pv;
	logic                  in_acc;
	logic                  in_range;
	logic                  out_free;
	logic                  qualify;
	logic                  step_ok;
	logic                  mem_we;
	logic                  sweep_start;
	logic                  frame_drop;
	logic                  sweep_step;
	logic                  fin_go;
	logic                  out_push;
	alu_op_t               alu_op;
	logic [COUNT_BITS-1:0] alu_a;
	logic [WEIGHT_W-1:0]   alu_b;
	logic [COUNT_BITS-1:0] alu_res;
	logic                  alu_ge;

	assign in_id    = s_tdata[ID_W-1:0];
	assign in_pv    = s_tdata[ID_W];
	assign in_acc   = s_tvalid && s_tready;
	assign in_range = (ID_W + 1)'(in_id) < ID_LIMIT;
	assign out_free = !out_valid_q || m_tready;
	assign addr     = (state_q == ST_DET_RD || state_q == ST_DET_WR) ? id_q : idx_q;
	assign alu_op   = (state_q == ST_DET_WR) ? ALU_ADD_CLAMP : ALU_SUB_FLOOR;
	assign alu_a    = rd_ok_q ? rd_data_q : '0;
	assign alu_b    = (state_q == ST_DET_WR) ? inc_q : dec_q;
	assign qualify  = seen_q[idx_q] && pv_flags_q[idx_q] && alu_ge;
	assign step_ok  = !(qualify && pend_valid_q) || out_free;
	assign pend_ext = WW'(pend_hits_q);

	thcc_alu #(
		.COUNT_BITS(COUNT_BITS)
	) u_alu (
		.op       (alu_op),
		.cnt      (alu_a),
		.weight   (alu_b),
		.max_hits (max_q),
		.threshold(thr_q),
		.result   (alu_res),
		.ge       (alu_ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		mem_we      = 1'b0;
		sweep_start = 1'b0;
		frame_drop  = 1'b0;
		sweep_step  = 1'b0;
		fin_go      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc) begin
					if (s_tuser) begin
						if (enable_q) begin
							sweep_start = 1'b1;
							state_d     = ST_SWP_RD;
						end else begin
							frame_drop = 1'b1;
						end
					end else if (enable_q && in_range) begin
						state_d = ST_DET_RD;
					end
				end
			end
			ST_DET_RD: state_d = ST_DET_WR;
			ST_DET_WR: begin
				mem_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SWP_RD: state_d = ST_SWP_EV;
			ST_SWP_EV: begin
				if (step_ok) begin
					sweep_step = 1'b1;
					mem_we     = !seen_q[idx_q];
					state_d    = (idx_q == IDX_LAST) ? ST_FIN : ST_SWP_RD;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					fin_go  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_push = (sweep_step && qualify && pend_valid_q) || fin_go;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			inc_q    <= WEIGHT_W'(1);
			dec_q    <= WEIGHT_W'(1);
			max_q    <= WEIGHT_W'(10);
			thr_q    <= WEIGHT_W'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:     enable_q <= cfg_wdata[0];
				REG_INC_WEIGHT: inc_q    <= cfg_wdata[WEIGHT_W-1:0];
				REG_DEC_WEIGHT: dec_q    <= cfg_wdata[WEIGHT_W-1:0];
				REG_MAX_HITS:   max_q    <= cfg_wdata[WEIGHT_W-1:0];
				REG_THRESHOLD:  thr_q    <= cfg_wdata[WEIGHT_W-1:0];
				default:        ;
			endcase
		end
	end

	// count memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= alu_res;
		end
		rd_data_q <= mem[addr];
		rd_ok_q   <= ok_q[addr];
	end

	// control state and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q         <= '0;
			seen_q       <= '0;
			pv_flags_q   <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				ok_q[addr] <= 1'b1;
			end
			if (state_q == ST_DET_WR) begin
				seen_q[id_q]     <= 1'b1;
				pv_flags_q[id_q] <= pv_q;
			end
			if (frame_drop || fin_go) begin
				seen_q     <= '0;
				pv_flags_q <= '0;
			end
			if (sweep_start) begin
				idx_q <= '0;
			end else if (sweep_step && idx_q != IDX_LAST) begin
				idx_q <= idx_q + AW'(1);
			end
			if (sweep_step && qualify) begin
				pend_valid_q <= 1'b1;
			end else if (fin_go) begin
				pend_valid_q <= 1'b0;
			end
			if (out_push) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q <= in_id[AW-1:0];
			pv_q <= in_pv;
		end
		if (sweep_step && qualify) begin
			pend_id_q   <= idx_q;
			pend_hits_q <= alu_a;
		end
		if (out_push) begin
			if (fin_go && !pend_valid_q) begin
				// empty frame marker
				out_id_q   <= '0;
				out_hits_q <= '0;
				out_pub_q  <= 1'b0;
			end else begin
				out_id_q   <= ID_W'(pend_id_q);
				out_hits_q <= pend_ext[HITS_W-1:0];
				out_pub_q  <= 1'b1;
			end
			out_last_q <= fin_go;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - ID_W - HITS_W){1'b0}}, out_hits_q, out_id_q};
	assign m_tuser  = out_pub_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("pending result left over outside a sweep");

	a_flags_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (seen_q == '0 && pv_flags_q == '0))
		else $error("frame flags not cleared after frame end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (!out_valid_q || m_tready))
		else $error("output register overwritten while held");
`endif

endmodule

// ----- bench/tag_hit_count_tracker_core_tb.sv -----
`timescale 1ns / 100ps

module tag_hit_count_tracker_core_tb;
	import thcc_pkg::*;

	localparam int TAG_IDS       = 64;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 315;
	localparam int CYCLE_LIMIT   = 1000000;

	localparam logic FUNC_DETECT    = 1'b0;
	localparam logic FUNC_FRAME_END = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [HITS_W-1:0] hits;
		logic              publish;
		logic              last;
	} tag_report_t;

	class tag_count_scoreboard;
		bit                enabled;
		logic [7:0]        inc_w;
		logic [7:0]        dec_w;
		logic [7:0]        max_hits;
		logic [7:0]        threshold;
		logic [HITS_W-1:0] counts [TAG_IDS];
		bit                seen [TAG_IDS];
		bit                point_ok [TAG_IDS];
		tag_report_t       expected_reports [$];
		int                errors;

		function new();
			enabled   = 1'b1;
			inc_w     = 8'd1;
			dec_w     = 8'd1;
			max_hits  = 8'd10;
			threshold = 8'd5;
			errors    = 0;
			foreach (counts[i]) begin
				counts[i]   = '0;
				seen[i]     = 1'b0;
				point_ok[i] = 1'b0;
			end
		endfunction

		function void set_reg(cfg_reg_e idx, logic [7:0] val);
			case (idx)
				REG_ENABLE:     enabled = val[0];
				REG_INC_WEIGHT: inc_w = val;
				REG_DEC_WEIGHT: dec_w = val;
				REG_MAX_HITS:   max_hits = val;
				REG_THRESHOLD:  threshold = val;
				default: ;
			endcase
		endfunction

		// called once per accepted input beat
		function void note_beat(logic func, logic [ID_W-1:0] id, logic pv);
			int          sum;
			int          n_pub;
			int          k;
			tag_report_t r;
			if (func == FUNC_DETECT) begin
				if (enabled) begin
					sum = int'(counts[id]) + int'(inc_w);
					counts[id]   = (sum > int'(max_hits)) ? max_hits : HITS_W'(sum);
					seen[id]     = 1'b1;
					point_ok[id] = pv;
				end
				return;
			end
			if (enabled) begin
				foreach (counts[i]) begin
					if (!seen[i])
						counts[i] = (counts[i] > dec_w) ? counts[i] - dec_w : '0;
				end
				n_pub = 0;
				foreach (counts[i]) begin
					if (seen[i] && point_ok[i] && counts[i] >= threshold)
						n_pub++;
				end
				k = 0;
				foreach (counts[i]) begin
					if (seen[i] && point_ok[i] && counts[i] >= threshold) begin
						r.id      = ID_W'(i);
						r.hits    = counts[i];
						r.publish = 1'b1;
						r.last    = (k == n_pub - 1);
						expected_reports = {expected_reports, r};
						k++;
					end
				end
				// nothing qualified: single empty-frame marker
				if (n_pub == 0) begin
					r = '0;
					r.last = 1'b1;
					expected_reports = {expected_reports, r};
				end
			end
			foreach (seen[i]) begin
				seen[i]     = 1'b0;
				point_ok[i] = 1'b0;
			end
		endfunction

		function void check_report(tag_report_t got);
			tag_report_t want;
			if (expected_reports.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: id %0d hits %0d publish %0b last %0b",
						got.id, got.hits, got.publish, got.last);
				return;
			end
			want = expected_reports.pop_front();
			if (got.id !== want.id || got.hits !== want.hits ||
				got.publish !== want.publish || got.last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: want id %0d hits %0d publish %0b last %0b,",
						want.id, want.hits, want.publish, want.last,
						" got id %0d hits %0d publish %0b last %0b",
						got.id, got.hits, got.publish, got.last);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	tag_count_scoreboard sb;
	int                  burst_left;
	int                  cycles;
	int                  stall_left;
	int                  mode_left;
	int                  rx_mode;

	tag_hit_count_tracker_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver: switches between always-ready, coin-flip and long stall stretches
	always @(negedge clk) begin
		if (mode_left <= 0) begin
			rx_mode   = $urandom_range(0, 2);
			mode_left = $urandom_range(20, 300);
		end else begin
			mode_left--;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom);
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						stall_left = $urandom_range(1, 8);
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_report('{id: m_tdata[5:0], hits: m_tdata[13:6],
				publish: m_tuser, last: m_tlast});
	end

	// called at a falling edge; returns at a falling edge with tvalid possibly still high
	task automatic issue(input logic func, input logic [ID_W-1:0] id, input logic pv);
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {1'b0, pv, id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_beat(func, id, pv);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic load_settings(input logic en, input logic [7:0] inc, input logic [7:0] dec,
		input logic [7:0] mx, input logic [7:0] thr);
		cfg_reg_e   idx [5];
		logic [7:0] val [5];
		idx = '{REG_ENABLE, REG_INC_WEIGHT, REG_DEC_WEIGHT, REG_MAX_HITS, REG_THRESHOLD};
		val = '{{7'd0, en}, inc, dec, mx, thr};
		foreach (idx[k]) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_wdata <= val[k];
			sb.set_reg(idx[k], val[k]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_setting(int lo, int hi);
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(lo, hi));
		endcase
	endfunction

	initial begin
		int              sent;
		logic [ID_W-1:0] pool [6];
		sb         = new();
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_ENABLE;
		cfg_wdata  = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = FUNC_DETECT;
		m_tready   = 1'b0;
		burst_left = 1;
		cycles     = 0;
		stall_left = 0;
		mode_left  = 0;
		rx_mode    = 0;
		sent       = 0;
		repeat (3)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings; repeated id, latest point flag wins, nothing reaches threshold
		issue(FUNC_DETECT, 6'd0, 1'b1);
		issue(FUNC_DETECT, 6'd63, 1'b1);
		issue(FUNC_DETECT, 6'd63, 1'b0);
		issue(FUNC_DETECT, 6'd63, 1'b1);
		issue(FUNC_FRAME_END, 6'd0, 1'b0);
		drain();

		// saturate at full scale, invalid point held back
		load_settings(1'b1, 8'd255, 8'd1, 8'd255, 8'd0);
		issue(FUNC_DETECT, 6'd0, 1'b1);
		issue(FUNC_DETECT, 6'd63, 1'b0);
		issue(FUNC_DETECT, 6'd5, 1'b1);
		issue(FUNC_FRAME_END, 6'd63, 1'b1);
		drain();

		// lowered clamp pulls a high count down
		load_settings(1'b1, 8'd255, 8'd1, 8'd3, 8'd0);
		issue(FUNC_DETECT, 6'd0, 1'b1);
		issue(FUNC_FRAME_END, 6'd0, 1'b0);
		drain();

		// disabled block ignores the frame, then a full decrement wipes everything
		load_settings(1'b0, 8'd1, 8'd255, 8'd3, 8'd0);
		issue(FUNC_DETECT, 6'd5, 1'b1);
		issue(FUNC_FRAME_END, 6'd0, 1'b0);
		drain();
		load_settings(1'b1, 8'd1, 8'd255, 8'd3, 8'd0);
		issue(FUNC_FRAME_END, 6'd42, 1'b1);
		drain();

		// zero weights and clamp, unreachable threshold
		load_settings(1'b1, 8'd0, 8'd0, 8'd0, 8'd255);
		issue(FUNC_DETECT, 6'd10, 1'b1);
		issue(FUNC_FRAME_END, 6'd0, 1'b0);
		drain();

		while (sent < RANDOM_ITEMS) begin
			load_settings($urandom_range(0, 7) != 0, pick_setting(1, 6), pick_setting(1, 4),
				pick_setting(3, 40), pick_setting(1, 8));
			foreach (pool[k])
				pool[k] = ID_W'($urandom);
			repeat ($urandom_range(3, 8)) begin
				repeat ($urandom_range(0, 10)) begin
					issue(FUNC_DETECT, ($urandom_range(0, 3) != 0) ?
						pool[$urandom_range(0, 5)] : ID_W'($urandom), 1'($urandom));
					sent++;
				end
				// occasionally run two frames' detections together
				if ($urandom_range(0, 15) != 0) begin
					issue(FUNC_FRAME_END, ID_W'($urandom), 1'($urandom));
					sent++;
				end
				if ($urandom_range(0, 19) == 0)
					drain();
			end
			drain();
		end

		drain();
		if (sb.errors == 0 && sb.expected_reports.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/thcc_pkg.sv
rtl/core/thcc_alu.sv
rtl/core/tag_hit_count_tracker_core.sv
bench/tag_hit_count_tracker_core_tb.sv
